FILE: rtl/bde_pkg.sv
package bde_pkg;

	localparam int CHANNELS   = 4;
	localparam int CH_W       = 2;
	localparam int WINDOW     = 10;
	localparam int SLOT_W     = $clog2(WINDOW);
	localparam int FILL_W     = $clog2(WINDOW + 1);
	localparam int MEM_AW     = CH_W + SLOT_W;
	localparam int MEM_DEPTH  = 1 << MEM_AW;

	localparam int TS_W       = 32;
	localparam int LVL_W      = 15;
	localparam int THR_W      = 16;
	localparam int RATE_W     = 24;
	localparam int SECS_W     = 20;
	localparam int HELD_W     = 4;

	localparam int IN_W       = 56;
	localparam int OUT_W      = 72;

	localparam int APB_AW     = 3;
	localparam int REG_IDX_W  = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_THRESH = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_CRIT   = 1'd1;
	localparam logic [THR_W-1:0] THRESH_RST = 16'd384;
	localparam logic [LVL_W-1:0] CRIT_RST   = 15'd5120;

	localparam int MUL_K      = 1000;
	localparam int DIV_NUM_W  = 25;
	localparam int DIV_DEN_W  = 32;
	localparam int DIV_CNT_W  = 5;
	localparam int RATE_STEPS = DIV_NUM_W;
	localparam int SECS_STEPS = LVL_W;

	localparam logic [RATE_W-1:0] RATE_MAX  = 24'h7FFFFF;
	localparam logic [RATE_W-1:0] RATE_MIN  = 24'h800000;
	localparam logic [SECS_W-1:0] SECS_MAX  = 20'hFFFFF;
	localparam logic [SECS_W-1:0] SECS_IDLE = 20'd9999;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PW    = 1;

	typedef struct packed {
		logic [TS_W-1:0]  ts;
		logic [LVL_W-1:0] lvl;
	} sample_t;

	typedef struct packed {
		logic [TS_W-1:0]   t_new;
		logic [LVL_W-1:0]  lvl_new;
		logic [TS_W-1:0]   t_old;
		logic [LVL_W-1:0]  lvl_old;
		logic [FILL_W-1:0] fill;
	} job_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: rtl/bde_front.sv
module bde_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [bde_pkg::CH_W-1:0]               in_ch,
	input  logic [bde_pkg::TS_W-1:0]               in_ts,
	input  logic [bde_pkg::LVL_W-1:0]              in_lvl,
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output bde_pkg::job_t                          push_job
);

	logic [bde_pkg::FILL_W-1:0] fill_q [bde_pkg::CHANNELS];
	logic [bde_pkg::SLOT_W-1:0] slot_q [bde_pkg::CHANNELS];
	bde_pkg::sample_t mem_q [bde_pkg::MEM_DEPTH];

	logic                        v_s1;
	logic [bde_pkg::TS_W-1:0]    ts_s1;
	logic [bde_pkg::LVL_W-1:0]   lvl_s1;
	logic [bde_pkg::FILL_W-1:0]  fill_s1;
	bde_pkg::sample_t            old_s1;

	logic                        accept;
	logic [bde_pkg::SLOT_W-1:0]  ws, ws_n, oldest;
	logic [bde_pkg::FILL_W-1:0]  fill_n;

	assign in_ready = !v_s1 || push_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ws = slot_q[in_ch];
		if (ws == bde_pkg::SLOT_W'(bde_pkg::WINDOW - 1)) begin
			ws_n = '0;
		end else begin
			ws_n = ws + 1'b1;
		end
		if (fill_q[in_ch] < bde_pkg::FILL_W'(bde_pkg::WINDOW)) begin
			fill_n = fill_q[in_ch] + 1'b1;
		end else begin
			fill_n = bde_pkg::FILL_W'(bde_pkg::WINDOW);
		end
		// until the ring is full the oldest entry sits in slot zero
		if (fill_n == bde_pkg::FILL_W'(bde_pkg::WINDOW)) begin
			oldest = ws_n;
		end else begin
			oldest = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bde_pkg::CHANNELS; i++) begin
				fill_q[i] <= '0;
				slot_q[i] <= '0;
			end
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fill_q[in_ch] <= fill_n;
				slot_q[in_ch] <= ws_n;
				v_s1 <= 1'b1;
			end else if (push_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[{in_ch, ws}] <= '{ts: in_ts, lvl: in_lvl};
			old_s1  <= mem_q[{in_ch, oldest}];
			ts_s1   <= in_ts;
			lvl_s1  <= in_lvl;
			fill_s1 <= fill_n;
		end
	end

	assign push_valid       = v_s1;
	assign push_job.t_new   = ts_s1;
	assign push_job.lvl_new = lvl_s1;
	assign push_job.t_old   = old_s1.ts;
	assign push_job.lvl_old = old_s1.lvl;
	assign push_job.fill    = fill_s1;

endmodule

FILE: rtl/bde_fifo.sv
module bde_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bde_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bde_pkg::job_t pop_job
);

	bde_pkg::job_t                 buf_q [bde_pkg::FIFO_DEPTH];
	logic [bde_pkg::FIFO_PW-1:0]   wr_q, rd_q;
	logic [bde_pkg::FIFO_PW:0]     cnt_q;
	logic                          do_push, do_pop;

	assign push_ready = cnt_q != (bde_pkg::FIFO_PW + 1)'(bde_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = buf_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= push_job;
		end
	end

endmodule

FILE: rtl/bde_div.sv
module bde_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bde_pkg::div_req_t req,
	output bde_pkg::div_rsp_t rsp
);

	logic [bde_pkg::DIV_DEN_W-1:0] rem_q, den_q;
	logic [bde_pkg::DIV_NUM_W-1:0] num_q, quot_q;
	logic [bde_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q, done_q;

	logic [bde_pkg::DIV_DEN_W:0]   trial;
	logic                          ge;
	logic [bde_pkg::DIV_DEN_W:0]   diff;

	// restoring division, one quotient bit per cycle from the numerator top
	always_comb begin
		trial = {rem_q, num_q[bde_pkg::DIV_NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bde_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			num_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[bde_pkg::DIV_DEN_W-1:0] : trial[bde_pkg::DIV_DEN_W-1:0];
			num_q  <= num_q << 1;
			quot_q <= {quot_q[bde_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: rtl/bde_back.sv
module bde_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  bde_pkg::job_t                    pop_job,
	input  logic [bde_pkg::THR_W-1:0]        thresh,
	input  logic [bde_pkg::LVL_W-1:0]        crit_lvl,
	output bde_pkg::div_req_t                div_req,
	input  bde_pkg::div_rsp_t                div_rsp,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bde_pkg::RATE_W-1:0]       out_rate,
	output logic                             out_high,
	output logic [bde_pkg::SECS_W-1:0]       out_crit,
	output logic [bde_pkg::SECS_W-1:0]       out_empty,
	output logic [bde_pkg::HELD_W-1:0]       out_held
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_RATE   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_CRIT   = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;
	localparam int PAD_W = bde_pkg::DIV_NUM_W - bde_pkg::LVL_W;

	logic [2:0]                    state_q;
	bde_pkg::job_t                 job_q;
	logic                          neg_q;
	logic [bde_pkg::RATE_W-1:0]    rate_q;
	logic [bde_pkg::SECS_W-1:0]    crit_q, empty_q;
	logic                          out_v_q;

	logic [bde_pkg::TS_W-1:0]      elapsed;
	logic                          rate_ok;
	logic signed [bde_pkg::LVL_W:0] ldiff;
	logic [bde_pkg::LVL_W-1:0]     mag;
	logic [bde_pkg::DIV_NUM_W-1:0] mag_k;
	logic [bde_pkg::RATE_W-1:0]    rate_sat;
	logic [bde_pkg::SECS_W-1:0]    secs_sat;
	logic                          rate_pos;
	logic                          below;
	logic [bde_pkg::LVL_W-1:0]     to_crit;
	logic                          high;

	always_comb begin
		elapsed = job_q.t_new - job_q.t_old;
		rate_ok = (job_q.fill >= bde_pkg::FILL_W'(2)) && (job_q.t_new > job_q.t_old);
		ldiff   = $signed({1'b0, job_q.lvl_old}) - $signed({1'b0, job_q.lvl_new});
		mag     = ldiff[bde_pkg::LVL_W] ? bde_pkg::LVL_W'(-ldiff) : ldiff[bde_pkg::LVL_W-1:0];
		mag_k   = bde_pkg::DIV_NUM_W'(mag) * bde_pkg::DIV_NUM_W'(bde_pkg::MUL_K);

		if (!neg_q) begin
			if (div_rsp.quot > bde_pkg::DIV_NUM_W'(bde_pkg::RATE_MAX)) begin
				rate_sat = bde_pkg::RATE_MAX;
			end else begin
				rate_sat = div_rsp.quot[bde_pkg::RATE_W-1:0];
			end
		end else begin
			if (div_rsp.quot > bde_pkg::DIV_NUM_W'(bde_pkg::RATE_MIN)) begin
				rate_sat = bde_pkg::RATE_MIN;
			end else begin
				rate_sat = -div_rsp.quot[bde_pkg::RATE_W-1:0];
			end
		end

		if (div_rsp.quot > bde_pkg::DIV_NUM_W'(bde_pkg::SECS_MAX)) begin
			secs_sat = bde_pkg::SECS_MAX;
		end else begin
			secs_sat = div_rsp.quot[bde_pkg::SECS_W-1:0];
		end

		rate_pos = !rate_q[bde_pkg::RATE_W-1] && (rate_q != '0);
		below    = job_q.lvl_new < crit_lvl;
		to_crit  = job_q.lvl_new - crit_lvl;
		high     = $signed({rate_q[bde_pkg::RATE_W-1], rate_q}) >
			$signed({{(bde_pkg::RATE_W + 1 - bde_pkg::THR_W){1'b0}}, thresh});
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = mag_k;
		div_req.den   = elapsed;
		div_req.steps = bde_pkg::DIV_CNT_W'(bde_pkg::RATE_STEPS);
		unique case (state_q)
			ST_PREP: begin
				div_req.start = rate_ok;
			end
			ST_DECIDE: begin
				div_req.start = rate_pos;
				div_req.num   = {(below ? job_q.lvl_new : to_crit), PAD_W'(0)};
				div_req.den   = bde_pkg::DIV_DEN_W'(rate_q);
				div_req.steps = bde_pkg::DIV_CNT_W'(bde_pkg::SECS_STEPS);
			end
			ST_CRIT: begin
				div_req.start = div_rsp.done;
				div_req.num   = {job_q.lvl_new, PAD_W'(0)};
				div_req.den   = bde_pkg::DIV_DEN_W'(rate_q);
				div_req.steps = bde_pkg::DIV_CNT_W'(bde_pkg::SECS_STEPS);
			end
			default: begin
			end
		endcase
	end

	assign pop_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_v_q || out_ready)) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= rate_ok ? ST_RATE : ST_DECIDE;
				end
				ST_RATE: begin
					if (div_rsp.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!rate_pos) begin
						state_q <= ST_OUT;
					end else if (below) begin
						state_q <= ST_EMPTY;
					end else begin
						state_q <= ST_CRIT;
					end
				end
				ST_CRIT: begin
					if (div_rsp.done) begin
						state_q <= ST_EMPTY;
					end
				end
				ST_EMPTY: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_v_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					job_q <= pop_job;
				end
			end
			ST_PREP: begin
				neg_q <= ldiff[bde_pkg::LVL_W];
				if (!rate_ok) begin
					rate_q <= '0;
				end
			end
			ST_RATE: begin
				if (div_rsp.done) begin
					rate_q <= rate_sat;
				end
			end
			ST_DECIDE: begin
				if (!rate_pos) begin
					crit_q  <= bde_pkg::SECS_IDLE;
					empty_q <= bde_pkg::SECS_IDLE;
				end else if (below) begin
					crit_q <= '0;
				end
			end
			ST_CRIT: begin
				if (div_rsp.done) begin
					crit_q <= secs_sat;
				end
			end
			ST_EMPTY: begin
				if (div_rsp.done) begin
					empty_q <= secs_sat;
				end
			end
			ST_OUT: begin
				if (!out_v_q || out_ready) begin
					out_rate  <= rate_q;
					out_high  <= high;
					out_crit  <= crit_q;
					out_empty <= empty_q;
					out_held  <= bde_pkg::HELD_W'(job_q.fill);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_v_q;

endmodule

FILE: rtl/battery_drain_estimator.sv
// Path: a registered sample stage, then the queue, then the back end states (prepare, rate,
// decide, critical, empty, output) before the result shows on m_tdata.
// Flow: the back end takes one sample at a time via the shared divider (one quotient bit a
// cycle: 25 bits for the rate, 15 for each time estimate); two samples may wait in the queue.
// Reset: arst_n clears fill counts, write slots, queue and handshake state; registers return
// to threshold 384 and critical level 5120. The sample ring holds no reset value.
module battery_drain_estimator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [1:0] channel, [33:2] timestamp_ms, [48:34] battery_level, [55:49] zero
	input  logic [bde_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [23:0] rate, [24] high_drain, [44:25] crit_secs,
	// [64:45] empty_secs, [68:65] samples_held, [71:69] zero
	output logic [bde_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bde_pkg::APB_AW-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic [bde_pkg::THR_W-1:0]  thresh_q;
	logic [bde_pkg::LVL_W-1:0]  crit_lvl_q;
	logic [bde_pkg::REG_IDX_W-1:0] reg_idx;

	logic              push_valid, push_ready, pop_valid, pop_ready;
	bde_pkg::job_t     push_job, pop_job;
	bde_pkg::div_req_t div_req;
	bde_pkg::div_rsp_t div_rsp;

	logic [bde_pkg::RATE_W-1:0] out_rate;
	logic                       out_high;
	logic [bde_pkg::SECS_W-1:0] out_crit, out_empty;
	logic [bde_pkg::HELD_W-1:0] out_held;

	assign pready  = 1'b1;
	assign reg_idx = paddr[bde_pkg::APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= bde_pkg::THRESH_RST;
			crit_lvl_q <= bde_pkg::CRIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				bde_pkg::REG_THRESH: thresh_q   <= pwdata[bde_pkg::THR_W-1:0];
				bde_pkg::REG_CRIT:   crit_lvl_q <= pwdata[bde_pkg::LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bde_pkg::REG_THRESH: prdata = 32'(thresh_q);
			bde_pkg::REG_CRIT:   prdata = 32'(crit_lvl_q);
			default:             prdata = '0;
		endcase
	end

	bde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_ch      (s_tdata[1:0]),
		.in_ts      (s_tdata[33:2]),
		.in_lvl     (s_tdata[48:34]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	bde_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	bde_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.thresh    (thresh_q),
		.crit_lvl  (crit_lvl_q),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rate  (out_rate),
		.out_high  (out_high),
		.out_crit  (out_crit),
		.out_empty (out_empty),
		.out_held  (out_held)
	);

	assign m_tdata = {3'b000, out_held, out_empty, out_crit, out_high, out_rate};

endmodule

FILE: rtl/bde_chk.sv
module bde_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [bde_pkg::OUT_W-1:0] m_tdata
);

	logic rate_pos;
	assign rate_pos = !m_tdata[23] && (m_tdata[23:0] != 24'd0);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_high_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[24] |-> rate_pos)
		else $error("high drain flagged without positive rate");

	a_idle_secs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !rate_pos |->
			m_tdata[44:25] == bde_pkg::SECS_IDLE && m_tdata[64:45] == bde_pkg::SECS_IDLE)
		else $error("time estimate not idle value for non-draining rate");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && rate_pos |-> m_tdata[44:25] <= m_tdata[64:45])
		else $error("time to critical exceeds time to empty");

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[68:65] != 4'd0 &&
			m_tdata[68:65] <= bde_pkg::HELD_W'(bde_pkg::WINDOW))
		else $error("sample count out of range");

endmodule

bind battery_drain_estimator bde_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     PHASE_ITEMS = 65;
	localparam longint RATE_HI     = 8388607;
	localparam longint RATE_LO     = -8388608;
	localparam longint SECS_HI     = 1048575;

	// fields from bit 0 up: rate, high, to_crit, to_empty, held, pad
	typedef struct packed {
		logic [2:0]                 pad;
		logic [bde_pkg::HELD_W-1:0] held;
		logic [bde_pkg::SECS_W-1:0] to_empty;
		logic [bde_pkg::SECS_W-1:0] to_crit;
		logic                       high;
		logic [bde_pkg::RATE_W-1:0] rate;
	} drain_result_t;

	typedef struct {
		int     ch;
		longint ts;
		int     lvl;
		bit     known;
		int     rate;
		int     high;
		int     to_crit;
		int     to_empty;
		int     held;
	} drill_row_t;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	// [1:0] channel, [33:2] timestamp_ms, [48:34] battery_level, [55:49] zero
	logic [bde_pkg::IN_W-1:0]   s_tdata  = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	// [23:0] rate, [24] high_drain, [44:25] crit_secs,
	// [64:45] empty_secs, [68:65] samples_held, [71:69] zero
	logic [bde_pkg::OUT_W-1:0]  m_tdata;
	logic                       psel     = 1'b0;
	logic                       penable  = 1'b0;
	logic                       pwrite   = 1'b0;
	logic [bde_pkg::APB_AW-1:0] paddr    = '0;
	logic [31:0]                pwdata   = '0;
	logic [31:0]                prdata;
	logic                       pready;

	battery_drain_estimator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [bde_pkg::TS_W-1:0]  ring_ts   [bde_pkg::CHANNELS][bde_pkg::WINDOW];
	logic [bde_pkg::LVL_W-1:0] ring_lvl  [bde_pkg::CHANNELS][bde_pkg::WINDOW];
	int                        ring_fill [bde_pkg::CHANNELS];
	int                        ring_slot [bde_pkg::CHANNELS];
	logic [bde_pkg::THR_W-1:0] thresh_reg;
	logic [bde_pkg::LVL_W-1:0] crit_reg;

	drain_result_t    pending_estimates[$];
	int               mismatch_count = 0;
	int               cycle_count    = 0;
	int               send_idle_pct  = 0;
	int               recv_idle_pct  = 0;
	int               stall_req      = 0;
	int               stall_left     = 0;

	logic [bde_pkg::TS_W-1:0] trace_ts  [bde_pkg::CHANNELS];
	int                       trace_lvl [bde_pkg::CHANNELS];
	drill_row_t               drill_rows[20];

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic logic [bde_pkg::SECS_W-1:0] secs_until(input longint num,
			input longint rate);
		longint q;
		q = num / rate;
		if (q > SECS_HI)
			q = SECS_HI;
		return q[bde_pkg::SECS_W-1:0];
	endfunction

	function automatic drain_result_t estimate_drain(input logic [bde_pkg::CH_W-1:0] ch,
			input logic [bde_pkg::TS_W-1:0] ts, input logic [bde_pkg::LVL_W-1:0] lvl);
		drain_result_t r;
		int            slot, newest, oldest;
		longint        t_new, t_old, lvl_new, lvl_old, elapsed, rate, thr;
		slot = ring_slot[ch];
		ring_ts[ch][slot] = ts;
		ring_lvl[ch][slot] = lvl;
		ring_slot[ch] = (slot + 1) % bde_pkg::WINDOW;
		if (ring_fill[ch] < bde_pkg::WINDOW)
			ring_fill[ch]++;
		rate = 0;
		if (ring_fill[ch] >= 2) begin
			newest = slot;
			oldest = (slot + 1 + bde_pkg::WINDOW - ring_fill[ch]) % bde_pkg::WINDOW;
			t_new = {32'd0, ring_ts[ch][newest]};
			t_old = {32'd0, ring_ts[ch][oldest]};
			elapsed = t_new - t_old;
			if (elapsed > 0) begin
				lvl_new = {49'd0, ring_lvl[ch][newest]};
				lvl_old = {49'd0, ring_lvl[ch][oldest]};
				rate = (lvl_old - lvl_new) * 1000 / elapsed;
				if (rate > RATE_HI)
					rate = RATE_HI;
				if (rate < RATE_LO)
					rate = RATE_LO;
			end
		end
		thr = {48'd0, thresh_reg};
		r.pad = '0;
		r.rate = rate[bde_pkg::RATE_W-1:0];
		r.high = rate > thr;
		r.held = bde_pkg::HELD_W'(ring_fill[ch]);
		if (rate <= 0) begin
			r.to_crit = bde_pkg::SECS_IDLE;
			r.to_empty = bde_pkg::SECS_IDLE;
		end else begin
			if (lvl < crit_reg)
				r.to_crit = '0;
			else
				r.to_crit = secs_until({49'd0, lvl} - {49'd0, crit_reg}, rate);
			r.to_empty = secs_until({49'd0, lvl}, rate);
		end
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge with the transfer done
	task automatic offer_sample(input logic [bde_pkg::CH_W-1:0] ch,
			input logic [bde_pkg::TS_W-1:0] ts, input logic [bde_pkg::LVL_W-1:0] lvl,
			input bit known, input drain_result_t typed);
		drain_result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, lvl, ts, ch};
		do @(posedge clk); while (!s_tready);
		want = estimate_drain(ch, ts, lvl);
		pending_estimates.insert(pending_estimates.size(), known ? typed : want);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [bde_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] value);
		logic [31:0] stored;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == bde_pkg::REG_THRESH) begin
			thresh_reg = value[bde_pkg::THR_W-1:0];
			stored = 32'(thresh_reg);
		end else begin
			crit_reg = value[bde_pkg::LVL_W-1:0];
			stored = 32'(crit_reg);
		end
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored)
			report_mismatch($sformatf("readback reg %0d got %0h expected %0h",
				idx, prdata, stored));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// sink side: random hold-off plus a long stall on request
	always @(negedge clk) begin
		if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		drain_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_estimates.size() == 0)
				report_mismatch($sformatf("result %h with nothing expected", m_tdata));
			else begin
				want = pending_estimates[0];
				pending_estimates.delete(0);
				if (got.rate !== want.rate)
					report_mismatch($sformatf("rate got %0d expected %0d",
						$signed(got.rate), $signed(want.rate)));
				if (got.high !== want.high)
					report_mismatch($sformatf("high_drain got %0d expected %0d",
						got.high, want.high));
				if (got.to_crit !== want.to_crit)
					report_mismatch($sformatf("crit_secs got %0d expected %0d",
						got.to_crit, want.to_crit));
				if (got.to_empty !== want.to_empty)
					report_mismatch($sformatf("empty_secs got %0d expected %0d",
						got.to_empty, want.to_empty));
				if (got.held !== want.held)
					report_mismatch($sformatf("samples_held got %0d expected %0d",
						got.held, want.held));
				if (got.pad !== want.pad)
					report_mismatch($sformatf("pad bits got %0h", got.pad));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		drain_result_t             typed;
		logic [bde_pkg::CH_W-1:0]  ch;
		logic [bde_pkg::TS_W-1:0]  ts;
		logic [bde_pkg::LVL_W-1:0] lvl;
		int                        pick, drop;

		for (int c = 0; c < bde_pkg::CHANNELS; c++) begin
			ring_fill[c] = 0;
			ring_slot[c] = 0;
		end
		thresh_reg = bde_pkg::THRESH_RST;
		crit_reg = bde_pkg::CRIT_RST;

		// ch, ts, lvl, known, rate, high, to_crit, to_empty, held
		drill_rows = '{
			'{0, 1000, 25600, 1, 0, 0, 9999, 9999, 1},
			'{0, 2000, 25344, 1, 256, 0, 79, 99, 2},
			'{1, 0, 0, 1, 0, 0, 9999, 9999, 1},
			'{1, 64'hFFFF_FFFF, 32767, 1, 0, 0, 9999, 9999, 2},
			'{2, 100, 32767, 1, 0, 0, 9999, 9999, 1},
			'{2, 101, 0, 1, 8388607, 1, 0, 0, 2},
			'{2, 102, 5120, 1, 8388607, 1, 0, 0, 3},
			'{3, 200, 0, 1, 0, 0, 9999, 9999, 1},
			'{3, 201, 32767, 1, -8388608, 0, 9999, 9999, 2},
			'{3, 150, 100, 1, 0, 0, 9999, 9999, 3},
			'{3, 200, 50, 1, 0, 0, 9999, 9999, 4},
			'{0, 3000000, 25343, 1, 0, 0, 9999, 9999, 3},
			'{0, 3001000, 25000, 0, 0, 0, 0, 0, 0},
			'{0, 3002000, 24600, 0, 0, 0, 0, 0, 0},
			'{0, 3003000, 24100, 0, 0, 0, 0, 0, 0},
			'{0, 3004000, 23900, 0, 0, 0, 0, 0, 0},
			'{0, 3005000, 23000, 0, 0, 0, 0, 0, 0},
			'{0, 3006000, 22800, 0, 0, 0, 0, 0, 0},
			'{0, 3007000, 22000, 0, 0, 0, 0, 0, 0},
			'{0, 3008000, 21500, 0, 0, 0, 0, 0, 0}
		};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 67;
		foreach (drill_rows[i]) begin
			typed.pad = '0;
			typed.rate = drill_rows[i].rate[bde_pkg::RATE_W-1:0];
			typed.high = drill_rows[i].high[0];
			typed.to_crit = drill_rows[i].to_crit[bde_pkg::SECS_W-1:0];
			typed.to_empty = drill_rows[i].to_empty[bde_pkg::SECS_W-1:0];
			typed.held = drill_rows[i].held[bde_pkg::HELD_W-1:0];
			offer_sample(drill_rows[i].ch[bde_pkg::CH_W-1:0],
				drill_rows[i].ts[bde_pkg::TS_W-1:0],
				drill_rows[i].lvl[bde_pkg::LVL_W-1:0], drill_rows[i].known, typed);
		end

		for (int c = 0; c < bde_pkg::CHANNELS; c++) begin
			trace_ts[c] = $urandom_range(1000000);
			trace_lvl[c] = 25600;
		end

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			unique case (p)
				0: begin
					write_reg(bde_pkg::REG_THRESH, 32'd0);
					write_reg(bde_pkg::REG_CRIT, 32'd0);
				end
				1: begin
					write_reg(bde_pkg::REG_THRESH, 32'd65535);
					write_reg(bde_pkg::REG_CRIT, 32'd25600);
				end
				3: begin
					write_reg(bde_pkg::REG_THRESH, 32'(bde_pkg::THRESH_RST));
					write_reg(bde_pkg::REG_CRIT, 32'(bde_pkg::CRIT_RST));
				end
				5: begin
					write_reg(bde_pkg::REG_THRESH, 32'd1);
					write_reg(bde_pkg::REG_CRIT, 32'($urandom_range(25600)));
				end
				default: begin
					write_reg(bde_pkg::REG_THRESH, 32'($urandom_range(3000)));
					write_reg(bde_pkg::REG_CRIT, 32'($urandom_range(25600)));
				end
			endcase
			send_idle_pct = (p < 2) ? 33 : (p < 4) ? 67 : 0;
			recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 33 : 0;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 4 && i == 10)
					stall_req = 300;
				if (p == 3 && i == 30)
					wait_idle();
				ch = $urandom_range(bde_pkg::CHANNELS - 1);
				pick = $urandom_range(99);
				if (pick < 72) begin
					// steady discharge
					ts = trace_ts[ch] + $urandom_range(2000, 1);
					drop = ($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(300);
					trace_lvl[ch] = (trace_lvl[ch] > drop) ? trace_lvl[ch] - drop : 25600;
				end else if (pick < 84) begin
					// charging
					ts = trace_ts[ch] + $urandom_range(2000, 1);
					trace_lvl[ch] = trace_lvl[ch] + $urandom_range(800, 1);
					if (trace_lvl[ch] > 32767)
						trace_lvl[ch] = 32767;
				end else if (pick < 92) begin
					// burst with tiny or zero spacing
					ts = trace_ts[ch] + $urandom_range(3);
					trace_lvl[ch] = $urandom_range(32767);
				end else begin
					ts = $urandom();
					trace_lvl[ch] = $urandom_range(32767);
				end
				trace_ts[ch] = ts;
				lvl = trace_lvl[ch][bde_pkg::LVL_W-1:0];
				typed = '0;
				offer_sample(ch, ts, lvl, 1'b0, typed);
			end
		end

		wait_idle();
		repeat (80) @(negedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bde_pkg.sv
rtl/bde_front.sv
rtl/bde_fifo.sv
rtl/bde_div.sv
rtl/bde_back.sv
rtl/battery_drain_estimator.sv
rtl/bde_chk.sv
bench/tb.sv
